>>> rtl/crb_pkg.sv
// ----------------------------------------------------------------------------
// Coil read response builder package
// Shared field widths, frame constants, command codes and beat structs.
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int WORD_INDEX_W = 6;
  localparam int COIL_W       = 16;
  localparam int ID_W         = 16;
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 16;
  localparam int QTY_W        = 9;
  localparam int POS_W        = 6;
  localparam int BCOUNT_W     = 7;
  localparam int LENGTH_W     = 16;
  localparam int WORD_ADDR_W  = 13;
  localparam int FRAME_POS_W  = 7;
  localparam int SHIFT_W      = 4;

  // Largest coil count a request may ask for; larger counts are clamped.
  localparam int MAX_QUANTITY = 256;
  localparam int QTY_LIMIT    = (MAX_QUANTITY > (1 << QTY_W) - 1) ?
                                ((1 << QTY_W) - 1) : MAX_QUANTITY;

  localparam int LENGTH_BASE  = 3;

  // Header byte offsets within the response frame.
  localparam logic [SHIFT_W-1:0] HDR_TID_HI   = 4'd0;
  localparam logic [SHIFT_W-1:0] HDR_TID_LO   = 4'd1;
  localparam logic [SHIFT_W-1:0] HDR_PID_HI   = 4'd2;
  localparam logic [SHIFT_W-1:0] HDR_PID_LO   = 4'd3;
  localparam logic [SHIFT_W-1:0] HDR_LEN_HI   = 4'd4;
  localparam logic [SHIFT_W-1:0] HDR_LEN_LO   = 4'd5;
  localparam logic [SHIFT_W-1:0] HDR_UNIT     = 4'd6;
  localparam logic [SHIFT_W-1:0] HDR_FUNC     = 4'd7;
  localparam logic [SHIFT_W-1:0] HDR_DATA_LEN = 4'd8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } command_t;

  typedef struct packed {
    command_t                command;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [COIL_W-1:0]       word_data;
    logic [ID_W-1:0]         transaction_id;
    logic [ID_W-1:0]         protocol_id;
    logic [BYTE_W-1:0]       unit_id;
    logic [BYTE_W-1:0]       function_code;
    logic [ADDR_W-1:0]       start_address;
    logic [QTY_W-1:0]        quantity;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    command_t                command;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [COIL_W-1:0]       word_data;
    logic [ID_W-1:0]         transaction_id;
    logic [ID_W-1:0]         protocol_id;
    logic [BYTE_W-1:0]       unit_id;
    logic [BYTE_W-1:0]       function_code;
    logic [ADDR_W-1:0]       start_address;
    logic [QTY_W-1:0]        quantity;
    logic [BCOUNT_W-1:0]     data_len;
  } cmd_t;

endpackage

>>> rtl/crb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/crb_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module crb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/crb_front.sv
// ----------------------------------------------------------------------------
// Coil read response builder front end
// Accepts input beats, drops loads beyond the store, clamps the coil count
// and works out the data byte count before queueing the command.
// ----------------------------------------------------------------------------
module crb_front #(
  parameter int STORE_WORDS = 64
) (
  input  crb_pkg::in_t  request,
  input  logic          push,
  output logic          full,
  output logic          cmd_push,
  output crb_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import crb_pkg::*;

  logic             load_in_range;
  logic [QTY_W-1:0] qty_clamped;
  logic [QTY_W:0]   qty_rounded;

  assign load_in_range = ({1'b0, request.word_index} < (WORD_INDEX_W + 1)'(STORE_WORDS));

  assign qty_clamped = (request.quantity > QTY_W'(QTY_LIMIT)) ?
                       QTY_W'(QTY_LIMIT) : request.quantity;
  assign qty_rounded = {1'b0, qty_clamped} + (QTY_W + 1)'(7);

  always_comb begin
    cmd.command        = request.command;
    cmd.word_index     = request.word_index;
    cmd.word_data      = request.word_data;
    cmd.transaction_id = request.transaction_id;
    cmd.protocol_id    = request.protocol_id;
    cmd.unit_id        = request.unit_id;
    cmd.function_code  = request.function_code;
    cmd.start_address  = request.start_address;
    cmd.quantity       = qty_clamped;
    cmd.data_len       = qty_rounded[QTY_W:3];
  end

  // A load that falls outside the store is taken and discarded here.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full &&
                    ((request.command == CMD_READ) || load_in_range);

endmodule

>>> rtl/crb_back.sv
// ----------------------------------------------------------------------------
// Coil read response builder back end
// Applies coil loads to the store and emits response frames byte by byte,
// sliding a two-word window over the store as the bit offset advances.
// ----------------------------------------------------------------------------
module crb_back #(
  parameter int STORE_WORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  crb_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output crb_pkg::out_t beat,
  output logic          out_push,
  input  logic          out_full
);
  import crb_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FETCH_LO = 5'b00010,
    ST_FETCH_HI = 5'b00100,
    ST_HEADER   = 5'b01000,
    ST_DATA     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [STORE_WORDS-1:0] valid;

  logic [ID_W-1:0]        tid;
  logic [ID_W-1:0]        pid;
  logic [BYTE_W-1:0]      unit;
  logic [BYTE_W-1:0]      func;
  logic [BCOUNT_W-1:0]    bcount;
  logic [BCOUNT_W-1:0]    bytes_left;
  logic [QTY_W-1:0]       bits_left;
  logic [SHIFT_W-1:0]     shift;
  logic [COIL_W-1:0]      lo_word;
  logic [WORD_ADDR_W-1:0] fetch_word;
  logic                   rd_zero;
  logic [FRAME_POS_W-1:0] pos;

  logic                   ram_we;
  logic                   ram_re;
  logic [COIL_W-1:0]      ram_rdata;
  logic [COIL_W-1:0]      hi_word;
  logic [2*COIL_W-1:0]    window;
  logic [BYTE_W-1:0]      bit_mask;
  logic [BYTE_W-1:0]      data_byte;
  logic [BYTE_W-1:0]      header_byte;
  logic [LENGTH_W-1:0]    frame_length;
  logic                   fetch_oob;

  crb_ram #(
    .WIDTH(COIL_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.word_index[AW-1:0]),
    .wdata(cmd.word_data),
    .re   (ram_re),
    .raddr(fetch_word[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Words past the store, or never loaded since reset, read as zero.
  assign fetch_oob = (fetch_word >= WORD_ADDR_W'(STORE_WORDS)) ||
                     !valid[fetch_word[AW-1:0]];

  assign hi_word   = rd_zero ? '0 : ram_rdata;
  assign window    = {hi_word, lo_word};
  assign bit_mask  = (bits_left >= QTY_W'(BYTE_W)) ? '1 : ~({BYTE_W{1'b1}} << bits_left[2:0]);
  assign data_byte = window[shift +: BYTE_W] & bit_mask;

  assign frame_length = LENGTH_W'(LENGTH_BASE) + LENGTH_W'(bcount);

  always_comb begin
    unique case (pos[SHIFT_W-1:0])
      HDR_TID_HI:   header_byte = tid[15:8];
      HDR_TID_LO:   header_byte = tid[7:0];
      HDR_PID_HI:   header_byte = pid[15:8];
      HDR_PID_LO:   header_byte = pid[7:0];
      HDR_LEN_HI:   header_byte = frame_length[15:8];
      HDR_LEN_LO:   header_byte = frame_length[7:0];
      HDR_UNIT:     header_byte = unit;
      HDR_FUNC:     header_byte = func;
      HDR_DATA_LEN: header_byte = BYTE_W'(bcount);
      default:      header_byte = '0;
    endcase
  end

  always_comb begin
    state_next         = state;
    cmd_pop            = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    out_push           = 1'b0;
    beat.tx_byte       = header_byte;
    beat.byte_position = pos[POS_W-1:0];
    beat.last          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.command == CMD_LOAD) begin
            ram_we = 1'b1;
          end else begin
            state_next = ST_FETCH_LO;
          end
        end
      end
      ST_FETCH_LO: begin
        ram_re     = 1'b1;
        state_next = ST_FETCH_HI;
      end
      ST_FETCH_HI: begin
        ram_re     = 1'b1;
        state_next = ST_HEADER;
      end
      ST_HEADER: begin
        beat.last = (pos[SHIFT_W-1:0] == HDR_DATA_LEN) && (bcount == '0);
        if (!out_full) begin
          out_push = 1'b1;
          if (pos[SHIFT_W-1:0] == HDR_DATA_LEN) begin
            state_next = (bcount == '0) ? ST_IDLE : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        beat.tx_byte = data_byte;
        beat.last    = (bytes_left == BCOUNT_W'(1));
        if (!out_full) begin
          out_push = 1'b1;
          ram_re   = shift[SHIFT_W-1];
          if (bytes_left == BCOUNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        valid[cmd.word_index[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Each read issue records whether the word it fetches counts as zero.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_zero    <= fetch_oob;
      fetch_word <= fetch_word + 1'b1;
    end
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty && (cmd.command == CMD_READ)) begin
          tid        <= cmd.transaction_id;
          pid        <= cmd.protocol_id;
          unit       <= cmd.unit_id;
          func       <= cmd.function_code;
          bcount     <= cmd.data_len;
          bytes_left <= cmd.data_len;
          bits_left  <= cmd.quantity;
          shift      <= cmd.start_address[SHIFT_W-1:0];
          fetch_word <= WORD_ADDR_W'(cmd.start_address[ADDR_W-1:SHIFT_W]);
        end
      end
      ST_FETCH_LO: begin
        pos <= '0;
      end
      ST_FETCH_HI: begin
        lo_word <= hi_word;
      end
      ST_HEADER: begin
        if (!out_full) begin
          pos <= pos + 1'b1;
        end
      end
      ST_DATA: begin
        if (!out_full) begin
          pos        <= pos + 1'b1;
          bytes_left <= bytes_left - 1'b1;
          bits_left  <= (bits_left >= QTY_W'(BYTE_W)) ? bits_left - QTY_W'(BYTE_W) : '0;
          shift      <= shift + SHIFT_W'(BYTE_W);
          if (shift[SHIFT_W-1]) begin
            lo_word <= hi_word;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/coil_read_response_builder.sv
// A read request passes through the command queue and the back end's idle,
// fetch-low and fetch-high states before its first header byte enters the
// result queue; a coil load is written to the store as the back end pops it.
// Frame bytes go out one per cycle while the result queue is not full.
// Reset clears both queues and marks every coil word as zero; no sweep.
// ----------------------------------------------------------------------------
// Coil read response builder
// Front end classifies requests into a command queue; the back end keeps the
// coil store and streams read-coils response frames into a result queue.
// ----------------------------------------------------------------------------
module coil_read_response_builder #(
  parameter int COIL_WORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  crb_pkg::in_t  request,
  input  logic          push,
  output logic          full,
  output crb_pkg::out_t response,
  output logic          empty,
  input  logic          pop
);
  import crb_pkg::*;

  // Only words a load can address need storage; the rest always read zero.
  localparam int STORE_WORDS = (COIL_WORDS < (1 << WORD_INDEX_W)) ?
                               COIL_WORDS : (1 << WORD_INDEX_W);
  localparam int CMD_DEPTH   = 2;
  localparam int OUT_DEPTH   = 2;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  out_t beat;
  logic out_push;
  logic out_full;

  crb_front #(
    .STORE_WORDS(STORE_WORDS)
  ) u_front (
    .request (request),
    .push    (push),
    .full    (full),
    .cmd_push(cmd_push),
    .cmd     (cmd_in),
    .cmd_full(cmd_full)
  );

  crb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_out),
    .empty(cmd_empty)
  );

  crb_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .beat     (beat),
    .out_push (out_push),
    .out_full (out_full)
  );

  crb_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(beat),
    .full (out_full),
    .pop  (pop),
    .rdata(response),
    .empty(empty)
  );

endmodule

>>> rtl/crb_checker.sv
// ----------------------------------------------------------------------------
// Coil read response builder port checker
// Watches the top-level ports for reset behaviour, result stability and the
// running byte position of the response frames.
// ----------------------------------------------------------------------------
module crb_checker (
  input logic          clk,
  input logic          rst,
  input crb_pkg::in_t  request,
  input logic          push,
  input logic          full,
  input crb_pkg::out_t response,
  input logic          empty,
  input logic          pop
);
  import crb_pkg::*;

  logic             prev_last;
  logic [POS_W-1:0] prev_pos;
  logic             out_beat;

  assign out_beat = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last <= 1'b1;
      prev_pos  <= '0;
    end else if (out_beat) begin
      prev_last <= response.last;
      prev_pos  <= response.byte_position;
    end
  end

  // Both queues come out of reset with nothing in them.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(response)))
    else $error("waiting result changed or vanished");

  // Frames start at position zero and count up by one beat at a time.
  a_position_runs: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (prev_last ? (response.byte_position == '0) :
                              (response.byte_position == POS_W'(prev_pos + 1'b1))))
    else $error("response byte position out of sequence");

  // The input beat is not checked here beyond its handshake.
  logic unused_in;
  assign unused_in = push ^ (^request);

endmodule

bind coil_read_response_builder crb_checker u_crb_checker (
  .clk     (clk),
  .rst     (rst),
  .request (request),
  .push    (push),
  .full    (full),
  .response(response),
  .empty   (empty),
  .pop     (pop)
);
